// ----- sv/dct_pkg.sv -----
package dct_pkg;

  // Request commands
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_e;

  // Completion status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  // One incoming request
  typedef struct packed {
    cmd_e        command;
    logic [7:0]  proc_id;
    logic [15:0] start_ticks;
  } req_t;

  // One outgoing response
  typedef struct packed {
    logic       ready_found;
    logic [7:0] ready_id;
    status_e    status;
    logic [4:0] entry_count;
  } rsp_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic insert;
    logic search_step;
    logic mark;
    logic miss;
    logic shift_start;
    logic shift_step;
    logic tick_step;
    logic dec_occ;
    logic out_load;
  } ctrl_t;

  // Status from the datapath to the controller
  typedef struct packed {
    cmd_e cmd;
    logic empty;
    logic hit;
    logic hit_tail;
    logic miss;
    logic at_last;
  } stat_t;

endpackage

// ----- sv/delay_countdown_table_core.sv -----
// Table of waiting processes, each with an id and a remaining tick count.
// Requests arrive on in_req_i under in_valid_i/in_ready_o: insert, remove,
// tick (every untaken positive count goes down by one) and ready query
// (newest expired untaken entry is returned and marked taken).
// Every request yields exactly one response on out_rsp_o under
// out_valid_o/out_ready_i, carrying the found flag, the id, a status and
// the number of entries held afterwards.
// One request is worked at a time. A remove, tick or query scans the entry
// memory one slot per cycle through its single read port, and a remove that
// must close a gap then moves each later entry down one slot. The next
// request is accepted in the cycle after the response is loaded.
// The response sits in an output register; a new request is taken while it
// waits, but the following response holds inside until the register frees.
// Reset empties the table at once; no clearing pass is needed.
module delay_countdown_table_core #(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned TICK_WIDTH  = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  dct_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output dct_pkg::rsp_t out_rsp_o
);

  dct_pkg::ctrl_t ctrl;
  dct_pkg::stat_t stat;

  // Sequencer.
  dct_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  // Entry memory, scan addressing and result registers.
  dct_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .TICK_WIDTH  (TICK_WIDTH)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_req_i  (in_req_i),
    .ctrl_i    (ctrl),
    .stat_o    (stat),
    .out_rsp_o (out_rsp_o)
  );

endmodule

// ----- sv/dct_ram.sv -----
module dct_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/dct_datapath.sv -----
module dct_datapath #(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned TICK_WIDTH  = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  dct_pkg::req_t  in_req_i,
  input  dct_pkg::ctrl_t ctrl_i,
  output dct_pkg::stat_t stat_o,
  output dct_pkg::rsp_t  out_rsp_o
);

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned EntW = TICK_WIDTH + 9;

  dct_pkg::cmd_e           cmd_q;
  logic [7:0]              pid_q;
  logic [TICK_WIDTH-1:0]   ticks_q;
  logic [CntW-1:0]         occ_q;
  logic [IdxW-1:0]         ra_q;
  logic [IdxW-1:0]         pa_q;
  logic                    pend_q;
  logic                    found_q;
  logic [7:0]              rid_q;
  dct_pkg::status_e        status_q;
  dct_pkg::rsp_t           out_q;

  logic                    we;
  logic [IdxW-1:0]         waddr;
  logic [EntW-1:0]         wdata;
  logic [EntW-1:0]         rd_data;
  logic [7:0]              r_id;
  logic [TICK_WIDTH-1:0]   r_ticks;
  logic                    r_taken;
  logic                    full;
  logic                    at_tail;
  logic                    ticks_zero;
  logic                    match;

  // Entry store: taken mark, remaining ticks and id in one word.
  dct_ram #(
    .WIDTH (EntW),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (ra_q),
    .rdata_o (rd_data)
  );

  // Fields of the entry read back for the slot in pa_q.
  assign r_id       = rd_data[7:0];
  assign r_ticks    = rd_data[8 +: TICK_WIDTH];
  assign r_taken    = rd_data[EntW-1];
  assign ticks_zero = (r_ticks == '0);
  assign full       = (occ_q == CntW'(TABLE_DEPTH));
  assign at_tail    = (CntW'(pa_q) == (occ_q - CntW'(1)));

  // Removal matches the id; a query wants an expired entry not yet taken.
  assign match = (cmd_q == dct_pkg::CMD_REMOVE) ? (r_id == pid_q)
                                                : (!r_taken && ticks_zero);

  always_comb begin
    stat_o.cmd      = cmd_q;
    stat_o.empty    = (occ_q == '0);
    stat_o.hit      = pend_q && match;
    stat_o.hit_tail = at_tail;
    stat_o.miss     = pend_q && !match && (pa_q == '0);
    stat_o.at_last  = pend_q && at_tail;
  end

  // Write port selection.
  always_comb begin
    we    = 1'b0;
    waddr = pa_q;
    wdata = rd_data;
    if (ctrl_i.insert) begin
      we    = !full;
      waddr = IdxW'(occ_q);
      wdata = {1'b0, ticks_q, pid_q};
    end else if (ctrl_i.mark) begin
      we    = 1'b1;
      waddr = pa_q;
      wdata = {1'b1, r_ticks, r_id};
    end else if (ctrl_i.shift_step) begin
      we    = pend_q;
      waddr = pa_q - IdxW'(1);
      wdata = rd_data;
    end else if (ctrl_i.tick_step) begin
      we    = pend_q && !r_taken && !ticks_zero;
      waddr = pa_q;
      wdata = {1'b0, r_ticks - TICK_WIDTH'(1), r_id};
    end
  end

  // Scan addresses: ra_q is the slot being read, pa_q the slot whose data
  // has arrived, pend_q says that data is valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ra_q   <= '0;
      pa_q   <= '0;
      pend_q <= 1'b0;
      occ_q  <= '0;
    end else begin
      if (ctrl_i.load) begin
        ra_q   <= (in_req_i.command == dct_pkg::CMD_TICK) ? '0
                                                          : IdxW'(occ_q - CntW'(1));
        pend_q <= 1'b0;
      end else if (ctrl_i.shift_start) begin
        ra_q   <= pa_q + IdxW'(1);
        pend_q <= 1'b0;
      end else if (ctrl_i.search_step) begin
        pa_q   <= ra_q;
        ra_q   <= ra_q - IdxW'(1);
        pend_q <= 1'b1;
      end else if (ctrl_i.shift_step || ctrl_i.tick_step) begin
        pa_q   <= ra_q;
        ra_q   <= ra_q + IdxW'(1);
        pend_q <= 1'b1;
      end
      if (ctrl_i.insert && !full) begin
        occ_q <= occ_q + CntW'(1);
      end else if (ctrl_i.dec_occ) begin
        occ_q <= occ_q - CntW'(1);
      end
    end
  end

  // Request capture and result fields.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q    <= in_req_i.command;
      pid_q    <= in_req_i.proc_id;
      ticks_q  <= TICK_WIDTH'(in_req_i.start_ticks);
      found_q  <= 1'b0;
      rid_q    <= '0;
      status_q <= dct_pkg::ST_OK;
    end
    if (ctrl_i.insert && full) begin
      status_q <= dct_pkg::ST_FULL;
    end
    if (ctrl_i.miss) begin
      status_q <= dct_pkg::ST_NOT_FOUND;
    end
    if (ctrl_i.mark) begin
      found_q <= 1'b1;
      rid_q   <= r_id;
    end
    if (ctrl_i.out_load) begin
      out_q.ready_found <= found_q;
      out_q.ready_id    <= rid_q;
      out_q.status      <= status_q;
      out_q.entry_count <= 5'(occ_q);
    end
  end

  assign out_rsp_o = out_q;

endmodule

// ----- sv/dct_ctrl.sv -----
module dct_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  dct_pkg::stat_t stat_i,
  output dct_pkg::ctrl_t ctrl_o
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_SEARCH   = 3'd2;
  localparam logic [2:0] S_SHIFT    = 3'd3;
  localparam logic [2:0] S_TICK     = 3'd4;
  localparam logic [2:0] S_DONE     = 3'd5;

  logic [2:0] state_q;
  logic [2:0] state_d;
  logic       out_valid_q;
  logic       out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // Next state and datapath commands.
  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          state_d     = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat_i.cmd)
          dct_pkg::CMD_INSERT: begin
            ctrl_o.insert = 1'b1;
            state_d       = S_DONE;
          end
          dct_pkg::CMD_REMOVE: begin
            ctrl_o.miss = stat_i.empty;
            state_d     = stat_i.empty ? S_DONE : S_SEARCH;
          end
          dct_pkg::CMD_TICK: begin
            state_d = stat_i.empty ? S_DONE : S_TICK;
          end
          default: begin
            state_d = stat_i.empty ? S_DONE : S_SEARCH;
          end
        endcase
      end
      S_SEARCH: begin
        if (stat_i.hit) begin
          if (stat_i.cmd == dct_pkg::CMD_REMOVE) begin
            if (stat_i.hit_tail) begin
              ctrl_o.dec_occ = 1'b1;
              state_d        = S_DONE;
            end else begin
              ctrl_o.shift_start = 1'b1;
              state_d            = S_SHIFT;
            end
          end else begin
            ctrl_o.mark = 1'b1;
            state_d     = S_DONE;
          end
        end else if (stat_i.miss) begin
          ctrl_o.miss = (stat_i.cmd == dct_pkg::CMD_REMOVE);
          state_d     = S_DONE;
        end else begin
          ctrl_o.search_step = 1'b1;
        end
      end
      S_SHIFT: begin
        ctrl_o.shift_step = 1'b1;
        if (stat_i.at_last) begin
          ctrl_o.dec_occ = 1'b1;
          state_d        = S_DONE;
        end
      end
      S_TICK: begin
        ctrl_o.tick_step = 1'b1;
        if (stat_i.at_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          ctrl_o.out_load = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // The output register is full until the response is taken.
  assign out_valid_d = ctrl_o.out_load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- tb/delay_countdown_table_core_test.sv -----
`timescale 1ns / 1ps

module delay_countdown_table_core_test;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned TICK_BITS   = 16;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned DRAIN_WAIT  = 2 * DEPTH + 32;

  // One request waiting to be offered, with the idle cycles before it.
  typedef struct {
    dct_pkg::req_t req;
    int unsigned   gap;
    bit            drain;
  } pending_req_t;

  logic          clk_i;
  logic          rst_ni      = 1'b0;
  logic          in_valid_i  = 1'b0;
  dct_pkg::req_t in_req_i    = '0;
  logic          out_ready_i = 1'b0;
  logic          in_ready_o;
  logic          out_valid_o;
  dct_pkg::rsp_t out_rsp_o;

  pending_req_t  req_backlog_q[$];
  dct_pkg::rsp_t due_rsp_q[$];
  bit            failed = 1'b0;

  // Generator-side view of the ids held, used to aim removes at live entries.
  logic [7:0] held_ids_q[$];
  bit         gap_on = 1'b1;

  // Predicted contents of the table, oldest entry in slot 0.
  logic [7:0]           slot_id    [DEPTH];
  logic [TICK_BITS-1:0] slot_ticks [DEPTH];
  bit                   slot_taken [DEPTH];
  int                   slot_used = 0;

  // Sender gap bookkeeping.
  int unsigned gap_left  = 0;
  bit          gap_armed = 1'b0;

  // Receiver stall bookkeeping.
  int unsigned hold_left  = 0;
  int unsigned rsp_seen   = 0;
  bit          rx_idle_on = 1'b1;

  delay_countdown_table_core #(
    .TABLE_DEPTH(DEPTH),
    .TICK_WIDTH (TICK_BITS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Apply one request to the predicted table and return the response it yields.
  function automatic dct_pkg::rsp_t table_apply(dct_pkg::req_t r);
    dct_pkg::rsp_t rsp;
    int            hit;
    rsp        = '0;
    rsp.status = dct_pkg::ST_OK;
    hit        = -1;
    case (r.command)
      dct_pkg::CMD_INSERT: begin
        if (slot_used >= DEPTH) begin
          rsp.status = dct_pkg::ST_FULL;
        end else begin
          slot_id[slot_used]    = r.proc_id;
          slot_ticks[slot_used] = r.start_ticks[TICK_BITS-1:0];
          slot_taken[slot_used] = 1'b0;
          slot_used++;
        end
      end
      dct_pkg::CMD_REMOVE: begin
        for (int i = slot_used - 1; i >= 0; i--) begin
          if (slot_id[i] == r.proc_id) begin
            hit = i;
            break;
          end
        end
        if (hit < 0) begin
          rsp.status = dct_pkg::ST_NOT_FOUND;
        end else begin
          for (int i = hit; i + 1 < slot_used; i++) begin
            slot_id[i]    = slot_id[i+1];
            slot_ticks[i] = slot_ticks[i+1];
            slot_taken[i] = slot_taken[i+1];
          end
          slot_used--;
        end
      end
      dct_pkg::CMD_TICK: begin
        for (int i = 0; i < slot_used; i++) begin
          if (!slot_taken[i] && slot_ticks[i] != 0) slot_ticks[i] = slot_ticks[i] - 1'b1;
        end
      end
      default: begin
        for (int i = slot_used - 1; i >= 0; i--) begin
          if (!slot_taken[i] && slot_ticks[i] == 0) begin
            slot_taken[i]   = 1'b1;
            rsp.ready_found = 1'b1;
            rsp.ready_id    = slot_id[i];
            break;
          end
        end
      end
    endcase
    rsp.entry_count = 5'(slot_used);
    return rsp;
  endfunction

  // Append a request to the backlog and keep the generator's id list in step.
  task automatic queue_request(input dct_pkg::cmd_e c, input logic [7:0] id,
                               input logic [15:0] tk, input bit drain);
    pending_req_t item;
    item.req.command     = c;
    item.req.proc_id     = id;
    item.req.start_ticks = tk;
    item.gap             = gap_on ? $urandom_range(0, 15) : 0;
    item.drain           = drain;
    req_backlog_q.push_back(item);
    if (c == dct_pkg::CMD_INSERT && held_ids_q.size() < DEPTH) begin
      held_ids_q.push_back(id);
    end else if (c == dct_pkg::CMD_REMOVE) begin
      for (int i = held_ids_q.size() - 1; i >= 0; i--) begin
        if (held_ids_q[i] == id) begin
          held_ids_q.delete(i);
          break;
        end
      end
    end
  endtask

  task automatic report_field(input string fname, input int unsigned want,
                              input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
      failed = 1'b1;
    end
  endtask

  // Build the whole stimulus: a directed opening, then random phases.
  initial begin : build_stimulus
    int            mode;
    int            pick;
    int            ins_pct;
    int            rem_pct;
    int            tick_pct;
    logic [7:0]    id;
    logic [15:0]   tk;
    dct_pkg::cmd_e c;
    bit            drain;

    // Empty table: query finds nothing, remove misses, tick does nothing.
    queue_request(dct_pkg::CMD_QUERY, 8'hFF, 16'hFFFF, 1'b0);
    queue_request(dct_pkg::CMD_REMOVE, 8'h05, 16'h0000, 1'b0);
    queue_request(dct_pkg::CMD_TICK, 8'h00, 16'h0000, 1'b0);
    // Field extremes and a duplicated id.
    queue_request(dct_pkg::CMD_INSERT, 8'h00, 16'h0000, 1'b0);
    queue_request(dct_pkg::CMD_INSERT, 8'hFF, 16'hFFFF, 1'b0);
    queue_request(dct_pkg::CMD_INSERT, 8'h5A, 16'h0001, 1'b0);
    queue_request(dct_pkg::CMD_INSERT, 8'hA5, 16'h0002, 1'b0);
    queue_request(dct_pkg::CMD_INSERT, 8'h5A, 16'h0000, 1'b0);
    // Queries return the newest expired entry; taken entries are skipped.
    queue_request(dct_pkg::CMD_QUERY, 8'h00, 16'h0000, 1'b0);
    queue_request(dct_pkg::CMD_TICK, 8'hAA, 16'h5555, 1'b0);
    queue_request(dct_pkg::CMD_QUERY, 8'h00, 16'h0000, 1'b0);
    queue_request(dct_pkg::CMD_QUERY, 8'h00, 16'h0000, 1'b0);
    queue_request(dct_pkg::CMD_QUERY, 8'h00, 16'h0000, 1'b0);
    // Remove takes the newest of the duplicates, then an absent id.
    queue_request(dct_pkg::CMD_REMOVE, 8'h5A, 16'h0000, 1'b0);
    queue_request(dct_pkg::CMD_REMOVE, 8'h77, 16'h0000, 1'b0);
    // Fill the table, then overflow it.
    for (int i = 0; i < 12; i++) begin
      queue_request(dct_pkg::CMD_INSERT, 8'($urandom_range(0, 255)),
                    (i % 2) ? 16'hAAAA : 16'h5555, 1'b0);
    end
    queue_request(dct_pkg::CMD_INSERT, 8'h33, 16'h0003, 1'b0);
    // Removing the oldest entry moves every other one down.
    queue_request(dct_pkg::CMD_REMOVE, 8'h00, 16'h0000, 1'b0);

    // Random phases, each leaning towards filling, draining or a balance.
    for (int blk = 0; blk < 30; blk++) begin
      mode   = $urandom_range(0, 2);
      gap_on = ($urandom_range(0, 3) != 0);
      case (mode)
        0:       begin ins_pct = 50; rem_pct = 10; tick_pct = 25; end
        1:       begin ins_pct = 10; rem_pct = 45; tick_pct = 25; end
        default: begin ins_pct = 30; rem_pct = 25; tick_pct = 25; end
      endcase
      for (int k = 0; k < 60; k++) begin
        pick  = $urandom_range(0, 99);
        drain = (k == 0) && (blk == 0 || $urandom_range(0, 4) == 0);
        id    = 8'($urandom_range(0, 255));
        tk    = 16'($urandom_range(0, 65535));
        if (pick < ins_pct) begin
          c = dct_pkg::CMD_INSERT;
          if ($urandom_range(0, 9) < 7) id = 8'($urandom_range(0, 15));
          pick = $urandom_range(0, 99);
          if (pick < 75) tk = 16'($urandom_range(0, 4));
          else if (pick < 95) tk = 16'($urandom_range(0, 40));
        end else if (pick < ins_pct + rem_pct) begin
          c = dct_pkg::CMD_REMOVE;
          if (held_ids_q.size() != 0 && $urandom_range(0, 9) < 8) begin
            id = held_ids_q[$urandom_range(0, held_ids_q.size() - 1)];
          end
        end else if (pick < ins_pct + rem_pct + tick_pct) begin
          c = dct_pkg::CMD_TICK;
        end else begin
          c = dct_pkg::CMD_QUERY;
        end
        queue_request(c, id, tk, drain);
      end
    end
  end

  // Sender: offers the backlog one request at a time and predicts on accept.
  always @(posedge clk_i or negedge rst_ni) begin
    logic nxt_valid;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_req_i   <= '0;
      gap_armed  = 1'b0;
      gap_left   = 0;
    end else begin
      nxt_valid = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        due_rsp_q.push_back(table_apply(in_req_i));
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && req_backlog_q.size() != 0) begin
        if (!gap_armed) begin
          gap_left  = req_backlog_q[0].gap;
          gap_armed = 1'b1;
        end
        if (gap_left != 0) begin
          gap_left--;
        end else if (!req_backlog_q[0].drain || due_rsp_q.size() == 0) begin
          in_req_i  <= req_backlog_q[0].req;
          nxt_valid = 1'b1;
          gap_armed = 1'b0;
          void'(req_backlog_q.pop_front());
        end
      end
      in_valid_i <= nxt_valid;
    end
  end

  // Receiver: checks each response against the oldest prediction and stalls at random.
  always @(posedge clk_i or negedge rst_ni) begin
    dct_pkg::rsp_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left   = 0;
      rsp_seen    = 0;
      rx_idle_on  = 1'b1;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (due_rsp_q.size() == 0) begin
          $display("%0t: response with none outstanding, actual %p", $time, out_rsp_o);
          failed = 1'b1;
        end else begin
          want = due_rsp_q.pop_front();
          report_field("ready_found", want.ready_found, out_rsp_o.ready_found);
          report_field("ready_id", want.ready_id, out_rsp_o.ready_id);
          report_field("status", want.status, out_rsp_o.status);
          report_field("entry_count", want.entry_count, out_rsp_o.entry_count);
        end
        rsp_seen++;
        if (rsp_seen % 64 == 0) rx_idle_on = ($urandom_range(0, 3) != 0);
        // A long hold lets the block fill up and push back on its input.
        if (rsp_seen == 100 || rsp_seen == 1200) hold_left = LONG_HOLD;
        else hold_left = rx_idle_on ? $urandom_range(0, 15) : 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when neither channel moves for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // Reset once, then wait for the stimulus to drain and give the verdict.
  initial begin : run_control
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (req_backlog_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (due_rsp_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (!failed) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/dct_pkg.sv
sv/dct_ram.sv
sv/dct_datapath.sv
sv/dct_ctrl.sv
sv/delay_countdown_table_core.sv
tb/delay_countdown_table_core_test.sv
